[rtl/core/gcc_pkg.sv]
// ----------------------------------------------------------------------------
// gcc_pkg: shared types and constants for the connected-components block
// Field widths, request and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package gcc_pkg;

    localparam int NODE_W = 5;   // node index field width
    localparam int CNT_W  = 6;   // node_count register width
    localparam int COMP_W = 5;   // component number width

    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_RUN  = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_START = 7'b0000010,
        ST_POP   = 7'b0000100,
        ST_ROW   = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_EMIT  = 7'b0100000,
        ST_ERR   = 7'b1000000
    } state_t;

endpackage

[rtl/core/graph_connected_components.sv]
// ----------------------------------------------------------------------------
// graph_connected_components: connected components by depth-first search
// Edge loader and component walker over a small undirected graph.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): req_type 0 adds edge node_a - node_b to the matrix;
//   req_type 1 runs the search and emits one result per node in use.
//   Result channel (m_*): node, component number, end-of-component and
//   end-of-run marks, status. A rejected edge gives one result with status 1.
//   Config channel (cfg_*): writes node_count; write it only while idle.
// Timing:
//   A valid edge is written while the block stays idle. A rejected edge passes
//   through the error state and waits there for a free result register. A run
//   steps the sequencer through pop, row read and neighbor scan, pushing one
//   neighbor per cycle through a single lowest-bit finder; a held result
//   register stalls it at each emit. The block takes one request at a time
//   and is not ready while it works.
// Reset: edges cleared, node_count back to 32, no result pending.
// Stall: a held result register stops the walk until m_ready frees it.
// ----------------------------------------------------------------------------
module graph_connected_components
    import gcc_pkg::*;
#(
    parameter int MAX_NODES = 32
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_req_type,
    input  logic [NODE_W-1:0] s_node_a,
    input  logic [NODE_W-1:0] s_node_b,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [NODE_W-1:0] m_node_index,
    output logic [COMP_W-1:0] m_component_id,
    output logic              m_last_in_component,
    output logic              m_last_of_run,
    output logic              m_status,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data
);

    localparam int NodeCap = (MAX_NODES < 32) ? MAX_NODES : 32;
    localparam int IdxW    = $clog2(NodeCap);
    localparam int DepW    = $clog2(NodeCap + 1);

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    node_count_reg;
    logic [NodeCap-1:0]  visited_reg, visited_next;
    logic [DepW-1:0]     depth_reg, depth_next;
    logic [COMP_W-1:0]   comp_reg, comp_next;
    logic [IdxW-1:0]     cur_reg, cur_next;

    logic                m_valid_reg, m_valid_next;
    logic                out_load;
    logic [NODE_W-1:0]   out_node;
    logic [COMP_W-1:0]   out_comp;
    logic                out_lic, out_lor, out_status;
    logic [NODE_W-1:0]   m_node_index_reg;
    logic [COMP_W-1:0]   m_component_id_reg;
    logic                m_last_in_component_reg, m_last_of_run_reg, m_status_reg;

    logic [CNT_W-1:0]    n_eff;
    logic [NodeCap-1:0]  live_mask;
    logic                out_free, s_fire, edge_bad, all_done;

    logic                adj_set, adj_rd;
    logic [IdxW-1:0]     adj_rd_addr;
    logic [NodeCap-1:0]  adj_row;

    logic                stk_wr, stk_rd;
    logic [IdxW-1:0]     stk_wr_addr, stk_wr_data, stk_rd_addr, stk_rd_data;

    logic [NodeCap-1:0]  pick_mask;
    logic                pick_any;
    logic [IdxW-1:0]     pick_idx;

    // effective node count and live-node mask
    assign n_eff = (node_count_reg > CNT_W'(NodeCap)) ? CNT_W'(NodeCap) : node_count_reg;

    always_comb begin
        for (int i = 0; i < NodeCap; i++) begin
            live_mask[i] = (CNT_W'(i) < n_eff);
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign edge_bad  = ({1'b0, s_node_a} >= n_eff) || ({1'b0, s_node_b} >= n_eff);
    assign all_done  = ((visited_reg & live_mask) == live_mask);

    // shared finder: unvisited start node, or unvisited neighbor of cur
    assign pick_mask = ((state_reg == ST_SCAN) ? adj_row : '1) & live_mask & ~visited_reg;

    gcc_pick #(.NODES(NodeCap)) u_pick (
        .mask (pick_mask),
        .any  (pick_any),
        .idx  (pick_idx)
    );

    assign adj_set = s_fire && (s_req_type == REQ_EDGE) && !edge_bad;

    gcc_adj #(.NODES(NodeCap)) u_adj (
        .aclk    (aclk),
        .aresetn (aresetn),
        .set_en  (adj_set),
        .set_a   (s_node_a[IdxW-1:0]),
        .set_b   (s_node_b[IdxW-1:0]),
        .rd_en   (adj_rd),
        .rd_addr (adj_rd_addr),
        .rd_row  (adj_row)
    );

    gcc_stack #(.NODES(NodeCap)) u_stack (
        .aclk    (aclk),
        .wr_en   (stk_wr),
        .wr_addr (stk_wr_addr),
        .wr_data (stk_wr_data),
        .rd_en   (stk_rd),
        .rd_addr (stk_rd_addr),
        .rd_data (stk_rd_data)
    );

    always_comb begin
        state_next   = state_reg;
        visited_next = visited_reg;
        depth_next   = depth_reg;
        comp_next    = comp_reg;
        cur_next     = cur_reg;
        adj_rd       = 1'b0;
        adj_rd_addr  = stk_rd_data;
        stk_wr       = 1'b0;
        stk_wr_addr  = depth_reg[IdxW-1:0];
        stk_wr_data  = pick_idx;
        stk_rd       = 1'b0;
        stk_rd_addr  = IdxW'(depth_reg - 1'b1);
        out_load     = 1'b0;
        out_node     = NODE_W'(cur_reg);
        out_comp     = comp_reg;
        out_lic      = (depth_reg == '0);
        out_lor      = (depth_reg == '0) && all_done;
        out_status   = STATUS_OK;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_req_type == REQ_RUN) begin
                        visited_next = '0;
                        depth_next   = '0;
                        comp_next    = '0;
                        if (n_eff != '0) begin
                            state_next = ST_START;
                        end
                    end else if (edge_bad) begin
                        state_next = ST_ERR;
                    end
                end
            end
            ST_START: begin
                if (pick_any) begin
                    stk_wr       = 1'b1;
                    stk_wr_addr  = '0;
                    depth_next   = DepW'(1);
                    visited_next = visited_reg | (NodeCap'(1) << pick_idx);
                    state_next   = ST_POP;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP: begin
                stk_rd     = 1'b1;
                depth_next = depth_reg - 1'b1;
                state_next = ST_ROW;
            end
            ST_ROW: begin
                cur_next   = stk_rd_data;
                adj_rd     = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (pick_any) begin
                    // mark on push; push only while the stack has room
                    visited_next = visited_reg | (NodeCap'(1) << pick_idx);
                    if (depth_reg < DepW'(NodeCap)) begin
                        stk_wr     = 1'b1;
                        depth_next = depth_reg + 1'b1;
                    end
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (depth_reg != '0) begin
                        state_next = ST_POP;
                    end else begin
                        comp_next  = comp_reg + 1'b1;
                        state_next = all_done ? ST_IDLE : ST_START;
                    end
                end
            end
            ST_ERR: begin
                out_node   = '0;
                out_comp   = '0;
                out_lic    = 1'b0;
                out_lor    = 1'b1;
                out_status = STATUS_ERR;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NODE_COUNT_RST;
            visited_reg    <= '0;
            depth_reg      <= '0;
            comp_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            visited_reg <= visited_next;
            depth_reg   <= depth_next;
            comp_reg    <= comp_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                node_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        if (out_load) begin
            m_node_index_reg        <= out_node;
            m_component_id_reg      <= out_comp;
            m_last_in_component_reg <= out_lic;
            m_last_of_run_reg       <= out_lor;
            m_status_reg            <= out_status;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_node_index        = m_node_index_reg;
    assign m_component_id      = m_component_id_reg;
    assign m_last_in_component = m_last_in_component_reg;
    assign m_last_of_run       = m_last_of_run_reg;
    assign m_status            = m_status_reg;

    // stack never grows past the node capacity
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= DepW'(NodeCap))
        else $error("walk stack depth beyond capacity");

    // the finder never offers a node that is already marked
    a_pick_unvisited: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN || state_reg == ST_START) && pick_any) |-> !visited_reg[pick_idx])
        else $error("picked node already visited");

    // the final result of a run returns the sequencer to idle
    a_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_load && out_lor) |=> (state_reg == ST_IDLE))
        else $error("run did not end after its last result");

    // a rejected edge always closes its request
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_ERR) |-> m_last_of_run)
        else $error("error result without end-of-run mark");

    // a run with nodes in use starts the component search next cycle
    a_run_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_req_type == REQ_RUN && n_eff != '0) |=> (state_reg == ST_START))
        else $error("run request did not start the search");

endmodule

[rtl/core/gcc_adj.sv]
// ----------------------------------------------------------------------------
// gcc_adj: adjacency bit matrix
// Sets both symmetric bits of an edge together; registered row read.
// ----------------------------------------------------------------------------
module gcc_adj #(
    parameter int NODES = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       set_en,
    input  logic [$clog2(NODES)-1:0]   set_a,
    input  logic [$clog2(NODES)-1:0]   set_b,
    input  logic                       rd_en,
    input  logic [$clog2(NODES)-1:0]   rd_addr,
    output logic [NODES-1:0]           rd_row
);

    logic [NODES-1:0] rows_reg [NODES];
    logic [NODES-1:0] rd_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NODES; i++) begin
                rows_reg[i] <= '0;
            end
        end else if (set_en) begin
            rows_reg[set_a][set_b] <= 1'b1;
            // a self loop sets one bit only
            if (set_a != set_b) begin
                rows_reg[set_b][set_a] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_row_reg <= rows_reg[rd_addr];
        end
    end

    assign rd_row = rd_row_reg;

endmodule

[rtl/core/gcc_stack.sv]
// ----------------------------------------------------------------------------
// gcc_stack: depth-first walk stack
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module gcc_stack #(
    parameter int NODES = 32
) (
    input  logic                       aclk,
    input  logic                       wr_en,
    input  logic [$clog2(NODES)-1:0]   wr_addr,
    input  logic [$clog2(NODES)-1:0]   wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(NODES)-1:0]   rd_addr,
    output logic [$clog2(NODES)-1:0]   rd_data
);

    logic [$clog2(NODES)-1:0] mem [NODES];
    logic [$clog2(NODES)-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/gcc_pick.sv]
// ----------------------------------------------------------------------------
// gcc_pick: lowest-set-bit finder
// Shared by the start search and the neighbor scan.
// ----------------------------------------------------------------------------
module gcc_pick #(
    parameter int NODES = 32
) (
    input  logic [NODES-1:0]           mask,
    output logic                       any,
    output logic [$clog2(NODES)-1:0]   idx
);

    localparam int IdxW = $clog2(NODES);

    always_comb begin
        idx = '0;
        // scan downward so the lowest set bit wins
        for (int i = NODES - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = IdxW'(i);
            end
        end
    end

    assign any = |mask;

endmodule
